// ===== hdl/npir_pkg.sv =====
// Shared constants and controller command type for the image rotator.
`default_nettype none

package npir_pkg;

    // Frame store geometry
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);

    // Item and register field widths
    localparam int PIX_W       = 32;
    localparam int CFG_DIM_W   = 8;
    localparam int TRIG_W      = 16;
    localparam int CHAN_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Fixed point: Q2.14 trig terms
    localparam int FRAC_W      = 14;

    // Rotation datapath widths
    localparam int OFS_W       = (COL_W > ROW_W ? COL_W : ROW_W) + 1;
    localparam int PROD_W      = OFS_W + TRIG_W;
    localparam int SUM_W       = PROD_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_TERM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_TERM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS     = 3'd4;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 8'd128;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 8'd128;
    localparam logic [TRIG_W-1:0]    RST_COS_TERM     = 16'h4000;
    localparam logic [TRIG_W-1:0]    RST_SIN_TERM     = 16'h0000;
    localparam logic [CHAN_W-1:0]    RST_CHANNELS     = 3'd4;
    localparam logic [CHAN_W-1:0]    FULL_CHANNELS    = 3'd4;

    // Item actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch the input item
        logic load;     // write the store, advance load index
        logic pos;      // resolve output position, form offsets
        logic mul;      // rotation products
        logic sum;      // sums, truncation, bounds check
        logic addr;     // source address
        logic read;     // store read
        logic emit;     // result on the ports
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/npir_ctrl.sv =====
// Controller state machine sequencing loads and rotated fetches.
`default_nettype none

module npir_ctrl
    import npir_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       action,
    output logic            busy,
    output ctrl_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_POS  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_ADDR = 3'd5;
    localparam logic [2:0] S_READ = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (action == ACT_LOAD) ? S_LOAD : S_POS;
                end
            end
            S_LOAD: state_next = S_IDLE;
            S_POS:  state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_ADDR;
            S_ADDR: state_next = S_READ;
            S_READ: state_next = S_EMIT;
            S_EMIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands
    assign busy       = (state_reg != S_IDLE);
    assign cmd.accept = (state_reg == S_IDLE) && start;
    assign cmd.load   = (state_reg == S_LOAD);
    assign cmd.pos    = (state_reg == S_POS);
    assign cmd.mul    = (state_reg == S_MUL);
    assign cmd.sum    = (state_reg == S_SUM);
    assign cmd.addr   = (state_reg == S_ADDR);
    assign cmd.read   = (state_reg == S_READ);
    assign cmd.emit   = (state_reg == S_EMIT);

endmodule

`default_nettype wire

// ===== hdl/npir_datapath.sv =====
// Datapath: registers, frame store, position counters and rotation arithmetic.
`default_nettype none

module npir_datapath
    import npir_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    input  wire logic [PIX_W-1:0]      pixel_in,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic [PIX_W-1:0]           pixel_out,
    output logic                       last_of_frame,
    output logic                       done
);

    // Configuration registers
    logic [CFG_DIM_W-1:0]   width_cfg_reg;
    logic [CFG_DIM_W-1:0]   height_cfg_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic [CHAN_W-1:0]      chan_reg;

    // Counters
    logic [ADDR_W-1:0]      load_idx_reg;
    logic [COL_W-1:0]       col_reg;
    logic [ROW_W-1:0]       row_reg;

    // Item and pipeline registers
    logic [PIX_W-1:0]       pix_in_reg;
    logic signed [OFS_W-1:0] xt_reg;
    logic signed [OFS_W-1:0] yt_reg;
    logic                   last_reg;
    logic signed [PROD_W-1:0] p_xc_reg;
    logic signed [PROD_W-1:0] p_ys_reg;
    logic signed [PROD_W-1:0] p_xs_reg;
    logic signed [PROD_W-1:0] p_yc_reg;
    logic [COL_W-1:0]       src_x_reg;
    logic [ROW_W-1:0]       src_y_reg;
    logic                   inb_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [PIX_W-1:0]       rdata_reg;

    // Frame store
    logic [PIX_W-1:0]       store_mem [STORE_DEPTH];

    // Effective dimensions
    logic [DIM_W-1:0]       w_eff;
    logic [DIM_W-1:0]       h_eff;
    logic [2*DIM_W-1:0]     frame_size;
    logic [DIM_W-1:0]       cx;
    logic [DIM_W-1:0]       cy;

    always_comb
    begin
        if (width_cfg_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(width_cfg_reg) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(width_cfg_reg);

        if (height_cfg_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(height_cfg_reg);
    end

    assign frame_size = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);
    assign cx         = w_eff >> 1;
    assign cy         = h_eff >> 1;

    // Configuration writes; unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= RST_FRAME_WIDTH;
            height_cfg_reg <= RST_FRAME_HEIGHT;
            cos_reg        <= RST_COS_TERM;
            sin_reg        <= RST_SIN_TERM;
            chan_reg       <= RST_CHANNELS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: height_cfg_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_COS_TERM:     cos_reg        <= cfg_data[TRIG_W-1:0];
                REG_SIN_TERM:     sin_reg        <= cfg_data[TRIG_W-1:0];
                REG_CHANNELS:     chan_reg       <= cfg_data[CHAN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Load index: restart if past the frame, wrap after the last pixel
    logic [ADDR_W-1:0]   load_idx_eff;
    logic [ADDR_W:0]     load_idx_inc;
    logic [ADDR_W-1:0]   load_idx_next;

    always_comb
    begin
        load_idx_eff = ((2*DIM_W)'(load_idx_reg) >= frame_size) ? '0 : load_idx_reg;
        load_idx_inc = {1'b0, load_idx_eff} + 1'b1;
        if ((2*DIM_W)'(load_idx_inc) >= frame_size)
            load_idx_next = '0;
        else
            load_idx_next = load_idx_inc[ADDR_W-1:0];
    end

    // Output position: wrap stale counters, then advance in raster order
    logic [DIM_W-1:0] col_eff;
    logic [DIM_W-1:0] row_eff;
    logic [DIM_W-1:0] row_bump;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             last_next;

    always_comb
    begin
        if (DIM_W'(col_reg) >= w_eff)
        begin
            col_eff  = '0;
            row_bump = DIM_W'(row_reg) + 1'b1;
        end
        else
        begin
            col_eff  = DIM_W'(col_reg);
            row_bump = DIM_W'(row_reg);
        end
        row_eff   = (row_bump >= h_eff) ? '0 : row_bump;
        last_next = (col_eff == w_eff - 1'b1) && (row_eff == h_eff - 1'b1);

        col_inc = col_eff + 1'b1;
        row_inc = row_eff;
        if (col_inc >= w_eff)
        begin
            col_inc = '0;
            row_inc = row_eff + 1'b1;
            if (row_inc >= h_eff)
                row_inc = '0;
        end
        col_next = col_inc[COL_W-1:0];
        row_next = row_inc[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
                load_idx_reg <= load_idx_next;
            if (cmd.pos)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Rotation: sums, truncation toward zero, recentering, bounds
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] q_x;
    logic signed [SUM_W-1:0] q_y;
    logic signed [SUM_W-1:0] pos_x;
    logic signed [SUM_W-1:0] pos_y;
    logic                    inb_next;

    always_comb
    begin
        sum_x = SUM_W'(p_xc_reg) - SUM_W'(p_ys_reg);
        sum_y = SUM_W'(p_xs_reg) + SUM_W'(p_yc_reg);
        // bias negative sums so the arithmetic shift rounds toward zero
        q_x   = (sum_x + (sum_x[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0))) >>> FRAC_W;
        q_y   = (sum_y + (sum_y[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0))) >>> FRAC_W;
        pos_x = q_x + $signed(SUM_W'(cx));
        pos_y = q_y + $signed(SUM_W'(cy));
        inb_next = !pos_x[SUM_W-1] && !pos_y[SUM_W-1]
                   && (pos_x < $signed(SUM_W'(w_eff)))
                   && (pos_y < $signed(SUM_W'(h_eff)));
    end

    // Source address
    logic [ROW_W+DIM_W-1:0] addr_full;
    assign addr_full = (ROW_W+DIM_W)'(src_y_reg) * (ROW_W+DIM_W)'(w_eff)
                       + (ROW_W+DIM_W)'(src_x_reg);

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            pix_in_reg <= pixel_in;
        if (cmd.pos)
        begin
            xt_reg   <= $signed(OFS_W'(col_eff)) - $signed(OFS_W'(cx));
            yt_reg   <= $signed(OFS_W'(row_eff)) - $signed(OFS_W'(cy));
            last_reg <= last_next;
        end
        if (cmd.mul)
        begin
            p_xc_reg <= xt_reg * cos_reg;
            p_ys_reg <= yt_reg * sin_reg;
            p_xs_reg <= xt_reg * sin_reg;
            p_yc_reg <= yt_reg * cos_reg;
        end
        if (cmd.sum)
        begin
            src_x_reg <= pos_x[COL_W-1:0];
            src_y_reg <= pos_y[ROW_W-1:0];
            inb_reg   <= inb_next;
        end
        if (cmd.addr)
            addr_reg <= addr_full[ADDR_W-1:0];
    end

    // Frame store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            store_mem[load_idx_eff] <= pix_in_reg;
        if (cmd.read)
            rdata_reg <= store_mem[addr_reg];
    end

    // Result
    always_comb
    begin
        pixel_out = '0;
        if (inb_reg)
        begin
            pixel_out = rdata_reg;
            if (chan_reg < FULL_CHANNELS)
                pixel_out[PIX_W-1:PIX_W-8] = 8'h00;
        end
    end

    assign last_of_frame = cmd.emit & last_reg;
    assign done          = cmd.emit;

endmodule

`default_nettype wire

// ===== hdl/nearest_pixel_image_rotator.sv =====
// Top level of the nearest-neighbor image rotator.
//
// Usage:
//   Items enter on start/action/pixel_in and are taken at a clock edge where
//   start is high and busy is low. A load item (action 0) writes pixel_in to
//   the frame store at the next raster position; it gives no result. A fetch
//   item (action 1) gives one result: the next rotated output pixel in raster
//   order on pixel_out, with last_of_frame on the frame's final pixel, shown
//   for one cycle while done is high.
//   Registers go in through cfg_write/cfg_index/cfg_data while busy is low.
// Sequencing:
//   A load holds busy for its store write; a fetch holds busy until its
//   result is shown, so no new item is taken before the last is done. The
//   fetch steps are position, four 8x16 products, sums and bounds, address
//   multiply, one registered read of the frame store, and the result.
// Reset:
//   rst_n clears the controller, the load and output positions and the
//   registers to their defaults; the frame store holds garbage until loaded.
//   The receiver cannot stall: each result is valid for its done cycle only.
`default_nettype none

module nearest_pixel_image_rotator
    import npir_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  action,
    input  wire logic [PIX_W-1:0]      pixel_in,
    output logic                       done,
    output logic [PIX_W-1:0]           pixel_out,
    output logic                       last_of_frame,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;

    // Sequencer
    npir_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Store and arithmetic
    npir_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .pixel_in      (pixel_in),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_out     (pixel_out),
        .last_of_frame (last_of_frame),
        .done          (done)
    );

endmodule

`default_nettype wire

// ===== hdl/npir_checker.sv =====
// Port-level timing checks for the image rotator, bound to the top level.
`default_nettype none

module npir_checker
    import npir_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic action,
    input wire logic done,
    input wire logic last_of_frame
);

    // A result appears only inside a busy period
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside busy");

    // A load never produces a result on the next cycle
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_LOAD) |=> (busy && !done))
        else $error("load item produced a result");

    // Every accepted fetch delivers a result
    a_fetch_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_FETCH) |-> ##6 done)
        else $error("fetch result missing");

    // Frame end flag only with a result
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_frame |-> done)
        else $error("last_of_frame without done");

endmodule

bind nearest_pixel_image_rotator npir_checker u_npir_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .done          (done),
    .last_of_frame (last_of_frame)
);

`default_nettype wire

// ===== tb/rotator_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the image rotator: predicts each fetched pixel and compares it.
module rotator_checker
    import npir_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic                  action,
    input  wire logic [PIX_W-1:0]      pixel_in,
    input  wire logic                  done,
    input  wire logic [PIX_W-1:0]      pixel_out,
    input  wire logic                  last_of_frame,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         outstanding
);

    localparam longint Q14_ONE = longint'(1) << FRAC_W;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eof;
    } out_pixel_t;

    // Local copy of the frame store, raster positions and registers
    logic [PIX_W-1:0]     frame_mem [STORE_DEPTH];
    logic [ADDR_W-1:0]    load_pos;
    logic [COL_W-1:0]     out_col;
    logic [ROW_W-1:0]     out_row;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [TRIG_W-1:0]    cos_reg;
    logic [TRIG_W-1:0]    sin_reg;
    logic [CHAN_W-1:0]    chan_reg;

    out_pixel_t rotated_q [$];
    out_pixel_t want;
    out_pixel_t fresh;
    int         err_count = 0;

    // 0 reads as 1, anything past the store maximum saturates
    function automatic int dim_in_use(input logic [CFG_DIM_W-1:0] v, input int limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    // Load item: next raster slot of the source frame
    task automatic store_pixel(input logic [PIX_W-1:0] pix);
        int size;
        int pos;
        size = dim_in_use(width_reg, MAX_WIDTH) * dim_in_use(height_reg, MAX_HEIGHT);
        pos  = int'(load_pos);
        if (pos >= size)
            pos = 0;
        frame_mem[pos] = pix;
        pos++;
        if (pos >= size)
            pos = 0;
        load_pos = pos[ADDR_W-1:0];
    endtask

    // Fetch item: rotate the current output position back into the source
    task automatic rotate_fetch(output out_pixel_t res);
        int     w;
        int     h;
        int     c;
        int     r;
        longint cx;
        longint cy;
        longint xt;
        longint yt;
        longint cs;
        longint sn;
        longint xs;
        longint ys;
        w = dim_in_use(width_reg, MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        c = int'(out_col);
        r = int'(out_row);
        // position left over from a larger frame wraps first
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r >= h)
            r = 0;

        cx = w / 2;
        cy = h / 2;
        xt = c - cx;
        yt = r - cy;
        cs = longint'($signed(cos_reg));
        sn = longint'($signed(sin_reg));
        // signed division truncates toward zero
        xs = (xt * cs - yt * sn) / Q14_ONE + cx;
        ys = (xt * sn + yt * cs) / Q14_ONE + cy;

        res.pix = '0;
        if (xs >= 0 && ys >= 0 && xs < w && ys < h)
        begin
            res.pix = frame_mem[ys * w + xs];
            if (chan_reg < FULL_CHANNELS)
                res.pix[PIX_W-1:PIX_W-8] = 8'h00;
        end
        res.eof = (c == w - 1 && r == h - 1);

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        out_col = c[COL_W-1:0];
        out_row = r[ROW_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos   = '0;
            out_col    = '0;
            out_row    = '0;
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            cos_reg    = RST_COS_TERM;
            sin_reg    = RST_SIN_TERM;
            chan_reg   = RST_CHANNELS;
            rotated_q.delete();
        end
        else
        begin
            // result side: oldest prediction first
            if (done)
            begin
                if (rotated_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual pixel %h last %b",
                             $time, pixel_out, last_of_frame);
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (pixel_out !== want.pix)
                    begin
                        err_count++;
                        $display("%0t: pixel_out expected %h actual %h",
                                 $time, want.pix, pixel_out);
                    end
                    if (last_of_frame !== want.eof)
                    begin
                        err_count++;
                        $display("%0t: last_of_frame expected %b actual %b",
                                 $time, want.eof, last_of_frame);
                    end
                end
            end

            // register writes; unmapped indexes fall through
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  = cfg_data[CFG_DIM_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_data[CFG_DIM_W-1:0];
                    REG_COS_TERM:     cos_reg    = cfg_data[TRIG_W-1:0];
                    REG_SIN_TERM:     sin_reg    = cfg_data[TRIG_W-1:0];
                    REG_CHANNELS:     chan_reg   = cfg_data[CHAN_W-1:0];
                    default:          ;
                endcase
            end

            // item side
            if (start && !busy)
            begin
                if (action == ACT_LOAD)
                    store_pixel(pixel_in);
                else
                begin
                    rotate_fetch(fresh);
                    rotated_q.push_back(fresh);
                end
            end
        end
        mismatches  <= err_count;
        outstanding <= rotated_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the image rotator: clock, reset, item and register stimulus, verdict.
module tb;
    import npir_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 11;
    localparam int ITEM_TARGET   = 1750;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  action    = ACT_LOAD;
    logic [PIX_W-1:0]      pixel_in  = '0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    logic [PIX_W-1:0]      pixel_out;
    logic                  last_of_frame;
    int                    mismatches;
    int                    outstanding;

    // Geometry in use and load progress: fetches wait until every slot
    // of the frame has been loaded at least once
    int frame_w      = MAX_WIDTH;
    int frame_h      = MAX_HEIGHT;
    int load_pos     = 0;
    int loaded_count = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int phase_no;

    nearest_pixel_image_rotator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .pixel_in      (pixel_in),
        .done          (done),
        .pixel_out     (pixel_out),
        .last_of_frame (last_of_frame),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rotator_checker pixel_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .pixel_in      (pixel_in),
        .done          (done),
        .pixel_out     (pixel_out),
        .last_of_frame (last_of_frame),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int dim_in_use(input logic [CFG_DIM_W-1:0] v, input int limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    // Trig terms: axis angles, full 16-bit extremes, in-range and raw values
    function automatic logic [TRIG_W-1:0] random_trig();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        v    = $urandom_range(0, 32768);
        case (pick)
            0:       return 16'h4000;
            1:       return 16'hC000;
            2:       return 16'h0000;
            3:       return 16'h7FFF;
            4:       return 16'h8000;
            5:       return 16'd11585;
            6, 7:    return 16'(v - 16384);
            default: return TRIG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // All five registers, random bits above the dimension and channel fields, sometimes an unmapped index
    task automatic program_frame(input logic [CFG_DIM_W-1:0] w8,
                                 input logic [CFG_DIM_W-1:0] h8,
                                 input logic [TRIG_W-1:0]    cos_v,
                                 input logic [TRIG_W-1:0]    sin_v,
                                 input logic [CHAN_W-1:0]    chans);
        write_reg(REG_FRAME_WIDTH,  {8'($urandom), w8});
        write_reg(REG_FRAME_HEIGHT, {8'($urandom), h8});
        write_reg(REG_COS_TERM,     cos_v);
        write_reg(REG_SIN_TERM,     sin_v);
        write_reg(REG_CHANNELS,     {13'($urandom), chans});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                      CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
        frame_w = dim_in_use(w8, MAX_WIDTH);
        frame_h = dim_in_use(h8, MAX_HEIGHT);
    endtask

    // Wait for every predicted pixel, then let the last item finish
    task automatic drain(input int settle);
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Present one item and hold it until taken; start stays high afterwards
    task automatic send_item(input logic act, input logic [PIX_W-1:0] pix);
        start    <= 1'b1;
        action   <= act;
        pixel_in <= pix;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (act == ACT_LOAD)
        begin
            if (load_pos >= frame_w * frame_h)
                load_pos = 0;
            if (load_pos + 1 > loaded_count)
                loaded_count = load_pos + 1;
            load_pos++;
            if (load_pos >= frame_w * frame_h)
                load_pos = 0;
        end
    endtask

    // Gap after an item: mostly none, a few long; rarely a full drain
    task automatic sender_gap(input bit no_gaps);
        int  pick;
        int  gap;
        bit  flush;
        gap   = 0;
        flush = ($urandom_range(0, 59) == 0);
        if (!no_gaps)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 97)
                gap = $urandom_range(20, 80);
            else if (pick >= 85)
                gap = $urandom_range(4, 12);
            else if (pick >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0 || flush)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            if (flush)
                drain(0);
        end
    endtask

    // New geometry and trig for one phase; the first two hit the size extremes
    task automatic random_config(input int n);
        logic [CFG_DIM_W-1:0] w8;
        logic [CFG_DIM_W-1:0] h8;
        int                   shape;
        shape = $urandom_range(0, 9);
        if (n == 1)
        begin
            program_frame(8'd128, 8'd2, 16'h8000, 16'h7FFF, 3'd7);
            return;
        end
        if (n == 2)
        begin
            program_frame(8'd0, 8'd255, 16'hC000, 16'h4000, 3'd0);
            return;
        end
        case (shape)
            0:
            begin
                w8 = CFG_DIM_W'($urandom_range(128, 255));
                h8 = CFG_DIM_W'($urandom_range(0, 2));
            end
            1:
            begin
                w8 = CFG_DIM_W'($urandom_range(0, 2));
                h8 = CFG_DIM_W'($urandom_range(128, 255));
            end
            2:
            begin
                w8 = CFG_DIM_W'($urandom_range(0, 1));
                h8 = CFG_DIM_W'($urandom_range(0, 1));
            end
            default:
            begin
                w8 = CFG_DIM_W'($urandom_range(1, 16));
                h8 = CFG_DIM_W'($urandom_range(1, 16));
            end
        endcase
        program_frame(w8, h8, random_trig(), random_trig(), CHAN_W'($urandom_range(0, 7)));
    endtask

    // Mixed loads and fetches; a fetch waits for a fully loaded frame
    task automatic run_phase(input int n);
        int fetch_pct;
        bit no_gaps;
        fetch_pct = $urandom_range(40, 90);
        no_gaps   = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++)
        begin
            if (loaded_count >= frame_w * frame_h && $urandom_range(0, 99) < fetch_pct)
                send_item(ACT_FETCH, $urandom);
            else
                send_item(ACT_LOAD, random_pixel());
            sender_gap(no_gaps);
        end
        start <= 1'b0;
    endtask

    task automatic fetch_frame(input int n);
        for (int k = 0; k < n; k++)
            send_item(ACT_FETCH, random_pixel());
        start <= 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 3x2 frame with extreme pixels, then identity, 90 and 180 degrees
        program_frame(8'd3, 8'd2, 16'h4000, 16'h0000, 3'd4);
        send_item(ACT_LOAD, 32'h0000_0000);
        send_item(ACT_LOAD, 32'hFFFF_FFFF);
        send_item(ACT_LOAD, 32'hA5A5_A5A5);
        send_item(ACT_LOAD, 32'h5A5A_5A5A);
        send_item(ACT_LOAD, 32'h8000_0001);
        send_item(ACT_LOAD, 32'h7FFF_FFFE);
        fetch_frame(6);
        drain(SETTLE_CYCLES);
        program_frame(8'd3, 8'd2, 16'h0000, 16'h4000, 3'd3);
        fetch_frame(6);
        drain(SETTLE_CYCLES);
        program_frame(8'd3, 8'd2, 16'hC000, 16'h0000, 3'd0);
        fetch_frame(6);

        // Random phases, registers rewritten between them while idle
        phase_no = 1;
        while (items_sent < ITEM_TARGET)
        begin
            drain(SETTLE_CYCLES);
            random_config(phase_no);
            run_phase($urandom_range(30, 110));
            phase_no++;
        end

        drain(SETTLE_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
